@@ rtl/rotenc_pkg.sv @@
// ----------------------------------------------------------------------------
// rotenc_pkg
// Shared types and constants for the rotary encoder and push-button event
// decoder: event codes, register map and register reset values.
// ----------------------------------------------------------------------------
package rotenc_pkg;

   localparam int TIME_W  = 32;
   localparam int CFG_W   = 16;
   localparam int EVENT_W = 3;
   localparam int HIST_W  = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE   = 3'd0,
      EV_CLICK  = 3'd1,
      EV_DOUBLE = 3'd2,
      EV_LONG   = 3'd3,
      EV_CW     = 3'd4,
      EV_CCW    = 3'd5
   } event_code_type;

   // Register index, taken from the word address (byte address / 4)
   typedef enum logic [1:0] {
      CSR_DEBOUNCE     = 2'd0,
      CSR_LONG_PRESS   = 2'd1,
      CSR_DOUBLE_CLICK = 2'd2
   } csr_index_type;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 16'd25;
   localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = 16'd1000;
   localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = 16'd300;

   // Quadrature transitions that move the detent accumulator
   function automatic logic quad_is_up(input logic [HIST_W-1:0] h);
      return (h == 4'b1101) || (h == 4'b0100) || (h == 4'b0010) || (h == 4'b1011);
   endfunction

   function automatic logic quad_is_down(input logic [HIST_W-1:0] h);
      return (h == 4'b1110) || (h == 4'b0111) || (h == 4'b0001) || (h == 4'b1000);
   endfunction

endpackage

@@ rtl/rotary_encoder_button_events.sv @@
// ----------------------------------------------------------------------------
// rotary_encoder_button_events
// Pipeline: an accepted poll lands in the input register, and its event is
//   registered in the result register when that is free or being read out.
// Throughput: one poll per cycle while rsp_ready is high; the decode is a single
//   pass between the input register and the result register, with all state updated in it.
// Reset: synchronous, active high; clears pipeline valids and decoder state,
//   loads the timing registers with 25, 1000 and 300 ms.
// ----------------------------------------------------------------------------
module rotary_encoder_button_events (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_phase_a_level,
   input  logic                                  req_phase_b_level,
   input  logic                                  req_switch_level,
   input  logic [rotenc_pkg::TIME_W-1:0]         req_now_ms,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rotenc_pkg::EVENT_W-1:0]        rsp_event_code,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rotenc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rotenc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rotenc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                  csr_pready
);
   import rotenc_pkg::*;

   // Configuration registers
   logic [CFG_W-1:0] debounce_ff;
   logic [CFG_W-1:0] long_press_ff;
   logic [CFG_W-1:0] double_click_ff;
   csr_index_type    csr_index;
   logic             csr_write;

   // Input register
   logic              in_valid_ff;
   logic              in_a_ff;
   logic              in_b_ff;
   logic              in_sw_ff;
   logic [TIME_W-1:0] in_now_ff;

   // Decoder state
   logic [HIST_W-1:0]  hist_ff,       hist_in;
   logic signed [1:0]  acc_ff,        acc_in;
   logic               raw_ff,        raw_in;
   logic               debounced_ff,  debounced_in;
   logic [TIME_W-1:0]  change_time_ff, change_time_in;
   logic               held_ff,       held_in;
   logic [TIME_W-1:0]  press_time_ff, press_time_in;
   logic               pending_ff,    pending_in;
   logic [TIME_W-1:0]  click_time_ff, click_time_in;

   // Result register
   logic               rsp_valid_ff;
   event_code_type     rsp_code_ff;

   logic               advance;
   logic               move_cw;
   logic               move_ccw;
   logic               raw_pressed;
   logic               raw_changed;
   logic [TIME_W-1:0]  since_change;
   logic [TIME_W-1:0]  held_time;
   logic [TIME_W-1:0]  since_click;
   event_code_type     button_ev;
   event_code_type     ev_in;

   // ---------------------------------------------------------------- CSR port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff     <= DEBOUNCE_RESET;
         long_press_ff   <= LONG_PRESS_RESET;
         double_click_ff <= DOUBLE_CLICK_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DEBOUNCE:     debounce_ff     <= csr_pwdata[CFG_W-1:0];
            CSR_LONG_PRESS:   long_press_ff   <= csr_pwdata[CFG_W-1:0];
            CSR_DOUBLE_CLICK: double_click_ff <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_DEBOUNCE:     csr_prdata = {{(CSR_DATA_W-CFG_W){1'b0}}, debounce_ff};
         CSR_LONG_PRESS:   csr_prdata = {{(CSR_DATA_W-CFG_W){1'b0}}, long_press_ff};
         CSR_DOUBLE_CLICK: csr_prdata = {{(CSR_DATA_W-CFG_W){1'b0}}, double_click_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- handshake
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_a_ff   <= req_phase_a_level;
         in_b_ff   <= req_phase_b_level;
         in_sw_ff  <= req_switch_level;
         in_now_ff <= req_now_ms;
      end
   end

   // ---------------------------------------------------------------- rotation
   always_comb begin
      hist_in  = {hist_ff[1:0], in_a_ff, in_b_ff};
      acc_in   = acc_ff;
      move_cw  = 1'b0;
      move_ccw = 1'b0;
      if (quad_is_up(hist_in)) begin
         if (acc_ff == 2'sd1) begin
            acc_in  = 2'sd0;
            move_cw = 1'b1;
         end else begin
            acc_in = acc_ff + 2'sd1;
         end
      end else if (quad_is_down(hist_in)) begin
         if (acc_ff == -2'sd1) begin
            acc_in   = 2'sd0;
            move_ccw = 1'b1;
         end else begin
            acc_in = acc_ff - 2'sd1;
         end
      end
   end

   // ---------------------------------------------------------------- button
   assign raw_pressed  = !in_sw_ff;
   assign raw_changed  = raw_pressed != raw_ff;
   assign since_change = raw_changed ? '0 : in_now_ff - change_time_ff;
   assign held_time    = in_now_ff - press_time_ff;
   assign since_click  = in_now_ff - click_time_ff;

   always_comb begin
      raw_in         = raw_pressed;
      change_time_in = raw_changed ? in_now_ff : change_time_ff;
      debounced_in   = debounced_ff;
      if (raw_pressed != debounced_ff &&
          since_change >= {{(TIME_W-CFG_W){1'b0}}, debounce_ff}) begin
         debounced_in = raw_pressed;
      end

      held_in       = held_ff;
      press_time_in = press_time_ff;
      pending_in    = pending_ff;
      click_time_in = click_time_ff;
      button_ev     = EV_NONE;

      if (debounced_in && !held_ff) begin
         held_in       = 1'b1;
         press_time_in = in_now_ff;
         if (pending_ff) begin
            pending_in = 1'b0;
            button_ev  = EV_DOUBLE;
         end
      end else if (!debounced_in && held_ff) begin
         held_in = 1'b0;
         if (held_time >= {{(TIME_W-CFG_W){1'b0}}, long_press_ff}) begin
            button_ev = EV_LONG;
         end else begin
            pending_in    = 1'b1;
            click_time_in = in_now_ff;
            button_ev     = EV_CLICK;
         end
      end else if (pending_ff &&
                   since_click > {{(TIME_W-CFG_W){1'b0}}, double_click_ff}) begin
         // close the double-click window
         pending_in = 1'b0;
      end
   end

   // Button event wins; the detent of the same poll is dropped
   always_comb begin
      ev_in = button_ev;
      if (button_ev == EV_NONE) begin
         if (move_cw) begin
            ev_in = EV_CW;
         end else if (move_ccw) begin
            ev_in = EV_CCW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff        <= '0;
         acc_ff         <= '0;
         raw_ff         <= 1'b0;
         debounced_ff   <= 1'b0;
         change_time_ff <= '0;
         held_ff        <= 1'b0;
         press_time_ff  <= '0;
         pending_ff     <= 1'b0;
         click_time_ff  <= '0;
      end else if (advance) begin
         hist_ff        <= hist_in;
         acc_ff         <= acc_in;
         raw_ff         <= raw_in;
         debounced_ff   <= debounced_in;
         change_time_ff <= change_time_in;
         held_ff        <= held_in;
         press_time_ff  <= press_time_in;
         pending_ff     <= pending_in;
         click_time_ff  <= click_time_in;
      end
   end

   // ---------------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_code_ff <= ev_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_code_ff;

`ifndef SYNTHESIS
   // The accumulator never rests at minus two
   assert property (@(posedge clock) disable iff (reset) acc_ff != 2'b10)
      else $error("step accumulator holds an unreduced detent");

   // Held flag tracks the debounced level after every poll
   assert property (@(posedge clock) disable iff (reset) held_ff == debounced_ff)
      else $error("button held flag out of step with debounced level");

   // A double click consumes a pending click
   assert property (@(posedge clock) disable iff (reset)
      advance && ev_in == EV_DOUBLE |-> pending_ff)
      else $error("double click without a pending click");

   // A delivered event is one of the defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_code <= EV_CCW))
      else $error("undefined event code on result");
`endif

endmodule

@@ dv/tb_rotary_encoder_button_events.sv @@
// ----------------------------------------------------------------------------
// tb_rotary_encoder_button_events
// Self-checking bench for the encoder and push-button event decoder. Polls
// (phase levels, switch level, timestamp) stream in over a valid/ready
// channel and each accepted poll is scored against an in-bench decoder
// model. Runs a short directed sequence, then random quadrature walks and
// bouncing button presses under several timing settings written over the
// register port, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_rotary_encoder_button_events;
   timeunit 1ns;
   timeprecision 1ps;

   import rotenc_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int REPORT_MAX = 10;
   localparam int LONG_HOLD_AT = 700;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   typedef struct {
      logic              phase_a;
      logic              phase_b;
      logic              sw;
      logic [TIME_W-1:0] now;
   } poll_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_phase_a_level = 1'b0;
   logic                  req_phase_b_level = 1'b0;
   logic                  req_switch_level = 1'b1;
   logic [TIME_W-1:0]     req_now_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [EVENT_W-1:0]    rsp_event_code;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rotary_encoder_button_events dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_phase_a_level(req_phase_a_level),
      .req_phase_b_level(req_phase_b_level),
      .req_switch_level(req_switch_level),
      .req_now_ms     (req_now_ms),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_code (rsp_event_code),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Decoder model state and timing registers
   logic [HIST_W-1:0] quad_hist = '0;
   int                spin_acc = 0;
   logic              raw_prev = 1'b0;
   logic              sw_stable = 1'b0;
   logic              held = 1'b0;
   logic              click_open = 1'b0;
   logic [TIME_W-1:0] raw_change_t = '0;
   logic [TIME_W-1:0] press_t = '0;
   logic [TIME_W-1:0] click_t = '0;
   logic [CFG_W-1:0]  cfg_debounce = DEBOUNCE_RESET;
   logic [CFG_W-1:0]  cfg_long = LONG_PRESS_RESET;
   logic [CFG_W-1:0]  cfg_double = DOUBLE_CLICK_RESET;

   poll_type       polls_to_send[$];
   event_code_type pending_events[$];
   poll_type       poll_out;
   int             polls_accepted = 0;
   int             cycle_cnt = 0;
   int             mismatches = 0;
   int             tx_gap = 0;
   int             rx_gap = 0;
   int             rx_hold_left = 0;
   logic           long_hold_done = 1'b0;
   logic           quiet;

   // Stimulus generator state
   logic [TIME_W-1:0] gen_now = '0;
   int                enc_pos = 0;
   int                enc_dir = 1;
   logic              gen_level = 1'b1;
   int                gen_ms_left = 0;
   int                gen_bounce = 0;

   // Drop idling on both sides for a stretch that recurs throughout the run
   assign quiet = (cycle_cnt % 1000) < 200;

   function automatic event_code_type decode_poll(input poll_type p);
      logic [HIST_W-1:0] h;
      logic              raw;
      logic [TIME_W-1:0] since;
      event_code_type    ev;
      int                turn;
      h = {quad_hist[1:0], p.phase_a, p.phase_b};
      quad_hist = h;
      case (h)
         4'b1101, 4'b0100, 4'b0010, 4'b1011: spin_acc++;
         4'b1110, 4'b0111, 4'b0001, 4'b1000: spin_acc--;
         default: ;
      endcase
      turn = 0;
      if (spin_acc >= 2) begin
         spin_acc = 0;
         turn = 1;
      end else if (spin_acc <= -2) begin
         spin_acc = 0;
         turn = -1;
      end

      ev = EV_NONE;
      raw = ~p.sw;
      if (raw != raw_prev) begin
         raw_prev = raw;
         raw_change_t = p.now;
      end
      since = p.now - raw_change_t;
      if (raw != sw_stable && since >= TIME_W'(cfg_debounce))
         sw_stable = raw;

      if (sw_stable && !held) begin
         held = 1'b1;
         press_t = p.now;
         if (click_open) begin
            click_open = 1'b0;
            ev = EV_DOUBLE;
         end
      end else if (!sw_stable && held) begin
         held = 1'b0;
         since = p.now - press_t;
         if (since >= TIME_W'(cfg_long)) begin
            ev = EV_LONG;
         end else begin
            click_open = 1'b1;
            click_t = p.now;
            ev = EV_CLICK;
         end
      end
      // Close an expired double-click window only on a quiet poll
      since = p.now - click_t;
      if (ev == EV_NONE && click_open && since > TIME_W'(cfg_double))
         click_open = 1'b0;

      // A button event swallows any detent in the same poll
      if (ev == EV_NONE && turn > 0)
         ev = EV_CW;
      else if (ev == EV_NONE && turn < 0)
         ev = EV_CCW;
      return ev;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void add_poll(input logic a, input logic b, input logic sw,
                                    input logic [TIME_W-1:0] now);
      poll_type p;
      p.phase_a = a;
      p.phase_b = b;
      p.sw = sw;
      p.now = now;
      polls_to_send.push_back(p);
   endfunction

   task automatic write_csr(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         CSR_DEBOUNCE:     cfg_debounce = data[CFG_W-1:0];
         CSR_LONG_PRESS:   cfg_long = data[CFG_W-1:0];
         CSR_DOUBLE_CLICK: cfg_double = data[CFG_W-1:0];
         default: ;
      endcase
   endtask

   // Upper data bits are junk; the registers keep only the low half
   task automatic set_timing(input int deb, input int lng, input int dbl);
      write_csr(CSR_DEBOUNCE, {16'($urandom), 16'(deb)});
      write_csr(CSR_LONG_PRESS, {16'($urandom), 16'(lng)});
      write_csr(CSR_DOUBLE_CLICK, {16'($urandom), 16'(dbl)});
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (polls_to_send.size() != 0 || req_valid || pending_events.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Quadrature walk plus a switch that presses and releases around the
   // current timing thresholds, with up to three bouncing polls on each edge
   task automatic queue_random_polls(input int count);
      int   k, r, dt, span, tick;
      logic a, b, sw;
      span = int'(cfg_debounce);
      if (int'(cfg_long) > span)
         span = int'(cfg_long);
      if (int'(cfg_double) > span)
         span = int'(cfg_double);
      tick = 1 + span / 64;
      if ($urandom_range(0, 1))
         gen_now = $urandom();
      else
         gen_now = 32'hFFFF_FFFF - $urandom_range(0, 20 * tick);
      gen_ms_left = 0;
      for (k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            add_poll(1'($urandom), 1'($urandom), 1'($urandom), $urandom());
         end else begin
            r = $urandom_range(0, 99);
            if (r < 2)
               dt = -int'($urandom_range(1, 60));
            else if (r < 6)
               dt = $urandom_range(0, 4 * span + 100);
            else
               dt = $urandom_range(0, 2 * tick);
            gen_now = gen_now + dt;

            r = $urandom_range(0, 99);
            if (r < 6)
               enc_dir = -enc_dir;
            if (r < 60)
               enc_pos = enc_pos + enc_dir;
            else if (r < 72)
               enc_pos = enc_pos - enc_dir;
            else if (r < 77)
               enc_pos = enc_pos + 2;
            enc_pos = enc_pos & 3;
            case (enc_pos)
               0: {a, b} = 2'b00;
               1: {a, b} = 2'b10;
               2: {a, b} = 2'b11;
               default: {a, b} = 2'b01;
            endcase

            if (dt > 0)
               gen_ms_left = gen_ms_left - dt;
            if (gen_ms_left <= 0) begin
               gen_level = ~gen_level;
               gen_bounce = $urandom_range(0, 3);
               r = $urandom_range(0, 99);
               if (!gen_level) begin
                  if (r < 45)
                     gen_ms_left = $urandom_range(0, int'(cfg_long));
                  else if (r < 70)
                     gen_ms_left = int'(cfg_long) + int'($urandom_range(0, 2 * tick)) - tick;
                  else
                     gen_ms_left = int'(cfg_long) + int'($urandom_range(0, cfg_long / 2 + 4 * tick));
               end else begin
                  if (r < 50)
                     gen_ms_left = $urandom_range(0, int'(cfg_double));
                  else if (r < 70)
                     gen_ms_left = int'(cfg_double) + int'($urandom_range(0, 2 * tick)) - tick;
                  else
                     gen_ms_left = int'(cfg_double) + int'($urandom_range(0, cfg_double + 8 * tick));
               end
            end
            if (gen_bounce > 0) begin
               sw = 1'($urandom);
               gen_bounce--;
            end else begin
               sw = gen_level;
            end
            add_poll(a, b, sw, gen_now);
         end
      end
   endtask

   task automatic note_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   // Poll driver: predict on acceptance, then offer the next poll or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            pending_events.push_back(decode_poll(poll_out));
            polls_accepted <= polls_accepted + 1;
         end
         if (!req_valid || req_ready) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (polls_to_send.size() > 0) begin
               poll_out = polls_to_send.pop_front();
               req_phase_a_level <= poll_out.phase_a;
               req_phase_b_level <= poll_out.phase_b;
               req_switch_level <= poll_out.sw;
               req_now_ms <= poll_out.now;
               req_valid <= 1'b1;
               if (!quiet)
                  tx_gap = idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Event receiver backpressure, with one long hold-off to fill the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_ready <= 1'b0;
      end else if (!long_hold_done && polls_accepted >= LONG_HOLD_AT) begin
         long_hold_done = 1'b1;
         rx_hold_left = LONG_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet)
            rx_gap = idle_len();
      end
   end

   // Event monitor
   always @(posedge clock) begin
      event_code_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            note_mismatch("event with no poll outstanding", -1, rsp_event_code);
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_code !== want)
               note_mismatch("event_code mismatch", want, rsp_event_code);
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_cnt);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Two clockwise detents, then two counterclockwise
      add_poll(1'b1, 1'b0, 1'b1, 32'd1000);
      add_poll(1'b1, 1'b1, 1'b1, 32'd1001);
      add_poll(1'b0, 1'b1, 1'b1, 32'd1002);
      add_poll(1'b0, 1'b0, 1'b1, 32'd1003);
      add_poll(1'b0, 1'b1, 1'b1, 32'd1004);
      add_poll(1'b1, 1'b1, 1'b1, 32'd1005);
      add_poll(1'b1, 1'b0, 1'b1, 32'd1006);
      add_poll(1'b0, 1'b0, 1'b1, 32'd1007);
      // Press, then a release whose click lands on a clockwise detent
      add_poll(1'b0, 1'b0, 1'b0, 32'd2000);
      add_poll(1'b0, 1'b0, 1'b0, 32'd2025);
      add_poll(1'b0, 1'b0, 1'b1, 32'd2100);
      add_poll(1'b1, 1'b0, 1'b1, 32'd2110);
      add_poll(1'b1, 1'b1, 1'b1, 32'd2125);
      // Double click, then a click
      add_poll(1'b1, 1'b1, 1'b0, 32'd2200);
      add_poll(1'b1, 1'b1, 1'b0, 32'd2225);
      add_poll(1'b1, 1'b1, 1'b1, 32'd2300);
      add_poll(1'b1, 1'b1, 1'b1, 32'd2325);
      // Press accepted after the window expired but before it was closed
      add_poll(1'b1, 1'b1, 1'b0, 32'd2600);
      add_poll(1'b1, 1'b1, 1'b0, 32'd2700);
      // Release held exactly the long-press time
      add_poll(1'b1, 1'b1, 1'b1, 32'd3675);
      add_poll(1'b1, 1'b1, 1'b1, 32'd3700);
      // Press and click across the timestamp wrap
      add_poll(1'b1, 1'b1, 1'b0, 32'hFFFF_FFF0);
      add_poll(1'b1, 1'b1, 1'b0, 32'h0000_0009);
      add_poll(1'b1, 1'b1, 1'b1, 32'h0000_0100);
      add_poll(1'b1, 1'b1, 1'b1, 32'h0000_0119);
      queue_random_polls(320);
      wait_idle();

      set_timing(0, 1000, 300);
      write_csr(CSR_UNMAPPED, 32'hFFFF_0007);
      queue_random_polls(320);
      wait_idle();

      set_timing(65535, 65535, 65535);
      queue_random_polls(320);
      wait_idle();

      set_timing(0, 0, 0);
      queue_random_polls(320);
      wait_idle();

      set_timing(5, 60, 40);
      queue_random_polls(320);
      wait_idle();

      set_timing($urandom_range(0, 40), $urandom_range(0, 400), $urandom_range(0, 300));
      queue_random_polls(320);
      wait_idle();

      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_events.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ rotary_encoder_button_events.f @@
rtl/rotenc_pkg.sv
rtl/rotary_encoder_button_events.sv
dv/tb_rotary_encoder_button_events.sv
